[design/phc_pkg.sv]
// Shared constants for the half-plane polygon clipper.
`default_nettype none
package phc_pkg;
    localparam int CoordWidth  = 32;
    localparam int CfgIdxWidth = 3;
    localparam int JobDepth    = 4;
    localparam int OutDepth    = 4;

    localparam logic [CfgIdxWidth-1:0] CfgLineStartX = 3'd0;
    localparam logic [CfgIdxWidth-1:0] CfgLineStartY = 3'd1;
    localparam logic [CfgIdxWidth-1:0] CfgLineEndX   = 3'd2;
    localparam logic [CfgIdxWidth-1:0] CfgLineEndY   = 3'd3;

    localparam logic KindVertex = 1'b0;
    localparam logic KindArea   = 1'b1;
endpackage
`default_nettype wire

[design/phc_queue.sv]
// Small register queue between stages.
`default_nettype none
module phc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    output logic                  o_full,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic      [WIDTH-1:0] o_data
);
    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0]  r_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

[design/phc_front.sv]
// Front part: line registers, vertex intake and edge job generation.
`default_nettype none
module phc_front #(
    parameter int COORD_WIDTH = phc_pkg::CoordWidth,
    localparam int JW = 4 * COORD_WIDTH + 1
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic [COORD_WIDTH-1:0]          i_vert_x,
    input  wire logic [COORD_WIDTH-1:0]          i_vert_y,
    input  wire logic                            i_last_vertex,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [phc_pkg::CfgIdxWidth-1:0] i_cfg_index,
    input  wire logic [COORD_WIDTH-1:0]          i_cfg_data,
    output logic      [COORD_WIDTH-1:0]          o_line_ax,
    output logic      [COORD_WIDTH-1:0]          o_line_ay,
    output logic      [COORD_WIDTH-1:0]          o_line_bx,
    output logic      [COORD_WIDTH-1:0]          o_line_by,
    output logic                                 o_job_valid,
    input  wire logic                            i_job_ready,
    output logic      [JW-1:0]                   o_job
);
    import phc_pkg::*;

    logic                   r_have_first, r_job_valid, r_pend;
    logic [COORD_WIDTH-1:0] r_first_x, r_first_y, r_prev_x, r_prev_y;
    logic [JW-1:0]          r_job, r_pend_job;
    logic                   w_accept, w_taken;

    assign full        = r_job_valid || r_pend;
    assign w_accept    = push && !full;
    assign w_taken     = r_job_valid && i_job_ready;
    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_line_ax <= '0;
            o_line_ay <= '0;
            o_line_bx <= '0;
            o_line_by <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CfgLineStartX: o_line_ax <= i_cfg_data;
                CfgLineStartY: o_line_ay <= i_cfg_data;
                CfgLineEndX:   o_line_bx <= i_cfg_data;
                CfgLineEndY:   o_line_by <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_first <= 1'b0;
            r_job_valid  <= 1'b0;
            r_pend       <= 1'b0;
            r_first_x    <= '0;
            r_first_y    <= '0;
            r_prev_x     <= '0;
            r_prev_y     <= '0;
        end else if (w_accept) begin
            r_prev_x <= i_vert_x;
            r_prev_y <= i_vert_y;
            if (!r_have_first) begin
                if (i_last_vertex) begin
                    // lone vertex: closing edge runs to itself
                    r_job       <= {i_vert_x, i_vert_y, i_vert_x, i_vert_y, 1'b1};
                    r_job_valid <= 1'b1;
                end else begin
                    r_have_first <= 1'b1;
                    r_first_x    <= i_vert_x;
                    r_first_y    <= i_vert_y;
                end
            end else begin
                r_job       <= {r_prev_x, r_prev_y, i_vert_x, i_vert_y, 1'b0};
                r_job_valid <= 1'b1;
                if (i_last_vertex) begin
                    r_pend       <= 1'b1;
                    r_pend_job   <= {i_vert_x, i_vert_y, r_first_x, r_first_y, 1'b1};
                    r_have_first <= 1'b0;
                end
            end
        end else if (w_taken) begin
            r_job_valid <= r_pend;
            r_pend      <= 1'b0;
            if (r_pend) begin
                r_job <= r_pend_job;
            end
        end
    end
endmodule
`default_nettype wire

[design/phc_lerp.sv]
// Serial intersection unit: rounded offset |d-c|*asc/aden for both axes.
`default_nettype none
module phc_lerp #(
    parameter int COORD_WIDTH = phc_pkg::CoordWidth,
    localparam int SW = 2 * COORD_WIDTH + 3
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [COORD_WIDTH-1:0] i_c_x,
    input  wire logic [COORD_WIDTH-1:0] i_c_y,
    input  wire logic [COORD_WIDTH-1:0] i_d_x,
    input  wire logic [COORD_WIDTH-1:0] i_d_y,
    input  wire logic [SW-1:0]          i_asc,
    input  wire logic [SW-1:0]          i_aden,
    output logic                        o_done,
    output logic      [COORD_WIDTH-1:0] o_x,
    output logic      [COORD_WIDTH-1:0] o_y
);
    import phc_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int DW   = CW + 1;
    localparam int QW   = DW + 1;
    localparam int RW   = SW + 2;
    localparam int CntW = $clog2(DW);

    logic              r_busy, r_fin;
    logic [CntW-1:0]   r_cnt;
    logic [SW-1:0]     r_asc, r_aden;
    logic [DW-1:0]     r_mag [2];
    logic              r_neg [2];
    logic [CW-1:0]     r_c   [2];
    logic [QW-1:0]     r_q   [2];
    logic [RW-1:0]     r_rem [2];

    logic [CW-1:0]     w_c [2];
    logic [CW-1:0]     w_d [2];
    logic signed [DW-1:0] w_diff [2];
    logic [RW-1:0]     w_t   [2];
    logic [RW-1:0]     w_nrem [2];
    logic [1:0]        w_dig [2];
    logic [QW-1:0]     w_off [2];
    logic [QW-1:0]     w_res [2];

    assign w_c[0] = i_c_x;
    assign w_c[1] = i_c_y;
    assign w_d[0] = i_d_x;
    assign w_d[1] = i_d_y;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_diff[l] = $signed({w_d[l][CW-1], w_d[l]}) - $signed({w_c[l][CW-1], w_c[l]});
            w_t[l] = {r_rem[l][RW-2:0], 1'b0}
                   + (r_mag[l][DW-1] ? {2'b00, r_asc} : RW'(0));
            if (w_t[l] >= {1'b0, r_aden, 1'b0}) begin
                w_nrem[l] = w_t[l] - {1'b0, r_aden, 1'b0};
                w_dig[l]  = 2'd2;
            end else if (w_t[l] >= {2'b00, r_aden}) begin
                w_nrem[l] = w_t[l] - {2'b00, r_aden};
                w_dig[l]  = 2'd1;
            end else begin
                w_nrem[l] = w_t[l];
                w_dig[l]  = 2'd0;
            end
            // round half away from zero on the magnitude
            w_off[l] = r_q[l] + QW'({r_rem[l], 1'b0} >= {3'b000, r_aden});
            w_res[l] = r_neg[l] ? ({{(QW - CW){r_c[l][CW-1]}}, r_c[l]} - w_off[l])
                                : ({{(QW - CW){r_c[l][CW-1]}}, r_c[l]} + w_off[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(DW - 1);
                r_asc  <= i_asc;
                r_aden <= i_aden;
                for (int l = 0; l < 2; l++) begin
                    r_neg[l] <= w_diff[l][DW-1];
                    r_mag[l] <= w_diff[l][DW-1] ? DW'(-w_diff[l]) : DW'(w_diff[l]);
                    r_c[l]   <= w_c[l];
                    r_q[l]   <= '0;
                    r_rem[l] <= '0;
                end
            end else if (r_busy) begin
                for (int l = 0; l < 2; l++) begin
                    r_rem[l] <= w_nrem[l];
                    r_q[l]   <= {r_q[l][QW-2:0], 1'b0} + QW'(w_dig[l]);
                    r_mag[l] <= {r_mag[l][DW-2:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                o_done <= 1'b1;
                o_x    <= w_res[0][CW-1:0];
                o_y    <= w_res[1][CW-1:0];
            end
        end
    end
endmodule
`default_nettype wire

[design/phc_back.sv]
// Back part: side tests, vertex emission and area accumulation per edge job.
`default_nettype none
module phc_back #(
    parameter int COORD_WIDTH = phc_pkg::CoordWidth,
    localparam int JW = 4 * COORD_WIDTH + 1,
    localparam int SW = 2 * COORD_WIDTH + 3,
    localparam int OW = 4 * COORD_WIDTH + 2
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [COORD_WIDTH-1:0] i_line_ax,
    input  wire logic [COORD_WIDTH-1:0] i_line_ay,
    input  wire logic [COORD_WIDTH-1:0] i_line_bx,
    input  wire logic [COORD_WIDTH-1:0] i_line_by,
    input  wire logic                   i_job_empty,
    output logic                        o_job_pop,
    input  wire logic [JW-1:0]          i_job,
    output logic                        o_lerp_start,
    output logic      [COORD_WIDTH-1:0] o_lerp_cx,
    output logic      [COORD_WIDTH-1:0] o_lerp_cy,
    output logic      [COORD_WIDTH-1:0] o_lerp_dx,
    output logic      [COORD_WIDTH-1:0] o_lerp_dy,
    output logic      [SW-1:0]          o_lerp_asc,
    output logic      [SW-1:0]          o_lerp_aden,
    input  wire logic                   i_lerp_done,
    input  wire logic [COORD_WIDTH-1:0] i_lerp_x,
    input  wire logic [COORD_WIDTH-1:0] i_lerp_y,
    input  wire logic                   i_out_full,
    output logic                        o_out_push,
    output logic      [OW-1:0]          o_out_data
);
    import phc_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int AW = 2 * CW;

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_DIFF   = 14'b00000000000010,
        S_MUL1   = 14'b00000000000100,
        S_MUL2   = 14'b00000000001000,
        S_SIDE   = 14'b00000000010000,
        S_DEC    = 14'b00000000100000,
        S_CHKI   = 14'b00000001000000,
        S_LERP   = 14'b00000010000000,
        S_EMIT   = 14'b00000100000000,
        S_AMUL   = 14'b00001000000000,
        S_ATERM  = 14'b00010000000000,
        S_ASAT   = 14'b00100000000000,
        S_END    = 14'b01000000000000,
        S_REPORT = 14'b10000000000000
    } t_state;

    t_state r_state;

    logic [CW-1:0]        r_cx, r_cy, r_dx, r_dy;
    logic                 r_close, r_need_i, r_after_i, r_have_out;
    logic signed [DW-1:0] r_vx, r_vy, r_ecx, r_ecy, r_edx, r_edy;
    logic signed [DW-1:0] r_ax, r_ay, r_bx, r_by;
    logic signed [PW-1:0] r_pa, r_pb;
    logic signed [SW-1:0] r_sc, r_den, r_term;
    logic [CW-1:0]        r_vtx_x, r_vtx_y;
    logic [CW-1:0]        r_of_x, r_of_y, r_op_x, r_op_y;
    logic [AW-1:0]        r_area;

    logic signed [SW-1:0] w_pdiff;
    logic signed [SW:0]   w_sd;
    logic                 w_need_i;
    logic [SW:0]          w_acc;
    logic [AW-1:0]        w_half;

    function automatic logic signed [DW-1:0] f_sub(input logic [CW-1:0] a,
                                                   input logic [CW-1:0] b);
        return $signed({a[CW-1], a}) - $signed({b[CW-1], b});
    endfunction

    assign w_pdiff  = $signed({r_pa[PW-1], r_pa}) - $signed({r_pb[PW-1], r_pb});
    assign w_sd     = $signed({r_sc[SW-1], r_sc}) - $signed({r_den[SW-1], r_den});
    // crossing when the end sides differ in sign or exactly one lies on the line
    assign w_need_i = (r_den != '0)
                   && ((r_sc == '0) || (w_sd == '0) || (r_sc[SW-1] != w_sd[SW]));
    assign w_acc    = {{(SW + 1 - AW){r_area[AW-1]}}, r_area} + {r_term[SW-1], r_term};
    assign w_half   = {r_area[AW-1], r_area[AW-1:1]};

    assign o_job_pop    = (r_state == S_IDLE) && !i_job_empty;
    assign o_lerp_start = (r_state == S_CHKI) && r_need_i;
    assign o_lerp_cx    = r_cx;
    assign o_lerp_cy    = r_cy;
    assign o_lerp_dx    = r_dx;
    assign o_lerp_dy    = r_dy;
    assign o_lerp_asc   = r_sc[SW-1] ? SW'(-r_sc) : SW'(r_sc);
    assign o_lerp_aden  = r_den[SW-1] ? SW'(-r_den) : SW'(r_den);

    assign o_out_push = ((r_state == S_EMIT) || (r_state == S_REPORT)) && !i_out_full;
    always_comb begin
        if (r_state == S_REPORT) begin
            o_out_data = {KindArea, {CW{1'b0}}, {CW{1'b0}}, w_half, 1'b1};
        end else begin
            o_out_data = {KindVertex, r_vtx_x, r_vtx_y, {AW{1'b0}}, 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_have_out <= 1'b0;
            r_area     <= '0;
            r_after_i  <= 1'b0;
            r_need_i   <= 1'b0;
            r_close    <= 1'b0;
            r_of_x     <= '0;
            r_of_y     <= '0;
            r_op_x     <= '0;
            r_op_y     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_job_empty) begin
                        r_cx    <= i_job[JW-1 -: CW];
                        r_cy    <= i_job[JW-1-CW -: CW];
                        r_dx    <= i_job[JW-1-2*CW -: CW];
                        r_dy    <= i_job[JW-1-3*CW -: CW];
                        r_close <= i_job[0];
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_vx    <= f_sub(i_line_bx, i_line_ax);
                    r_vy    <= f_sub(i_line_by, i_line_ay);
                    r_ecx   <= f_sub(r_cx, i_line_ax);
                    r_ecy   <= f_sub(r_cy, i_line_ay);
                    r_edx   <= f_sub(r_cx, r_dx);
                    r_edy   <= f_sub(r_cy, r_dy);
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_pa    <= r_vx * r_ecy;
                    r_pb    <= r_vy * r_ecx;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_sc    <= w_pdiff;
                    r_pa    <= r_vx * r_edy;
                    r_pb    <= r_vy * r_edx;
                    r_state <= S_SIDE;
                end
                S_SIDE: begin
                    r_den   <= w_pdiff;
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    r_need_i  <= w_need_i;
                    r_after_i <= 1'b0;
                    if (!r_sc[SW-1]) begin
                        r_vtx_x <= r_cx;
                        r_vtx_y <= r_cy;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_CHKI;
                    end
                end
                S_CHKI: begin
                    r_state <= r_need_i ? S_LERP : S_END;
                end
                S_LERP: begin
                    if (i_lerp_done) begin
                        r_vtx_x   <= i_lerp_x;
                        r_vtx_y   <= i_lerp_y;
                        r_after_i <= 1'b1;
                        r_state   <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!i_out_full) begin
                        r_op_x <= r_vtx_x;
                        r_op_y <= r_vtx_y;
                        if (!r_have_out) begin
                            r_have_out <= 1'b1;
                            r_of_x     <= r_vtx_x;
                            r_of_y     <= r_vtx_y;
                            r_state    <= r_after_i ? S_END : S_CHKI;
                        end else begin
                            r_ax    <= f_sub(r_op_x, r_of_x);
                            r_ay    <= f_sub(r_op_y, r_of_y);
                            r_bx    <= f_sub(r_vtx_x, r_of_x);
                            r_by    <= f_sub(r_vtx_y, r_of_y);
                            r_state <= S_AMUL;
                        end
                    end
                end
                S_AMUL: begin
                    r_pa    <= r_ax * r_by;
                    r_pb    <= r_ay * r_bx;
                    r_state <= S_ATERM;
                end
                S_ATERM: begin
                    r_term  <= w_pdiff;
                    r_state <= S_ASAT;
                end
                S_ASAT: begin
                    if ((w_acc[SW:AW-1] == '0) || (w_acc[SW:AW-1] == '1)) begin
                        r_area <= w_acc[AW-1:0];
                    end else if (w_acc[SW]) begin
                        r_area <= {1'b1, {(AW - 1){1'b0}}};
                    end else begin
                        r_area <= {1'b0, {(AW - 1){1'b1}}};
                    end
                    r_state <= r_after_i ? S_END : S_CHKI;
                end
                S_END: begin
                    r_state <= r_close ? S_REPORT : S_IDLE;
                end
                S_REPORT: begin
                    if (!i_out_full) begin
                        // drop the run state once the area is out
                        r_have_out <= 1'b0;
                        r_area     <= '0;
                        r_of_x     <= '0;
                        r_of_y     <= '0;
                        r_op_x     <= '0;
                        r_op_y     <= '0;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_lerp_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_lerp_start |-> (r_den != '0))
        else $error("intersection started on a parallel edge");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_push |-> !i_out_full)
        else $error("result pushed into a full queue");

    a_report_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REPORT) && !i_out_full |=> !r_have_out && (r_area == '0))
        else $error("run state not cleared after area report");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |=> (r_state == S_DIFF))
        else $error("job popped outside idle");
endmodule
`default_nettype wire

[design/polygon_halfplane_clip_area.sv]
// Top level of the half-plane polygon clipper with shoelace area.
//
// Vertices enter on a queue-like port and are clipped against the left side
// of the line A to B held in four registers. The front turns each vertex into
// edge jobs queued for the back sequencer; the last vertex of a polygon also
// queues the closing edge. The front takes no new vertex while an edge job is
// still waiting for the job queue. Per edge the back takes the job and forms
// the two cross products in S_IDLE through S_DEC, emits each output vertex in
// S_EMIT and adds its area term in S_AMUL, S_ATERM and S_ASAT (the first vertex
// of a run adds none), and waits in S_LERP on the serial intersection unit when
// the edge crosses the line. After the closing edge the area report goes out
// from S_REPORT. The back takes a new job only in S_IDLE, so it works on one
// edge at a time, and a full result queue stalls it in S_EMIT and S_REPORT.
`default_nettype none
module polygon_halfplane_clip_area #(
    parameter int COORD_WIDTH = phc_pkg::CoordWidth
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic [COORD_WIDTH-1:0]          i_vert_x,
    input  wire logic [COORD_WIDTH-1:0]          i_vert_y,
    input  wire logic                            i_last_vertex,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [phc_pkg::CfgIdxWidth-1:0] i_cfg_index,
    input  wire logic [COORD_WIDTH-1:0]          i_cfg_data,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic                                 o_kind,
    output logic      [COORD_WIDTH-1:0]          o_out_x,
    output logic      [COORD_WIDTH-1:0]          o_out_y,
    output logic      [2*COORD_WIDTH-1:0]        o_area,
    output logic                                 o_end_of_run
);
    import phc_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int JW = 4 * CW + 1;
    localparam int SW = 2 * CW + 3;
    localparam int OW = 4 * CW + 2;

    logic [CW-1:0] w_ax, w_ay, w_bx, w_by;
    logic          w_job_valid, w_jq_full, w_jq_empty, w_job_pop;
    logic [JW-1:0] w_job, w_jq_data;
    logic          w_lerp_start, w_lerp_done;
    logic [CW-1:0] w_lcx, w_lcy, w_ldx, w_ldy, w_lx, w_ly;
    logic [SW-1:0] w_asc, w_aden;
    logic          w_oq_full, w_out_push;
    logic [OW-1:0] w_out_data, w_oq_data;

    phc_front #(.COORD_WIDTH(CW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full),
        .i_vert_x(i_vert_x), .i_vert_y(i_vert_y), .i_last_vertex(i_last_vertex),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_line_ax(w_ax), .o_line_ay(w_ay), .o_line_bx(w_bx), .o_line_by(w_by),
        .o_job_valid(w_job_valid), .i_job_ready(!w_jq_full), .o_job(w_job)
    );

    phc_queue #(.WIDTH(JW), .DEPTH(JobDepth)) u_job_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_job_valid), .o_full(w_jq_full), .i_data(w_job),
        .i_pop(w_job_pop), .o_empty(w_jq_empty), .o_data(w_jq_data)
    );

    phc_lerp #(.COORD_WIDTH(CW)) u_lerp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_lerp_start),
        .i_c_x(w_lcx), .i_c_y(w_lcy), .i_d_x(w_ldx), .i_d_y(w_ldy),
        .i_asc(w_asc), .i_aden(w_aden),
        .o_done(w_lerp_done), .o_x(w_lx), .o_y(w_ly)
    );

    phc_back #(.COORD_WIDTH(CW)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_line_ax(w_ax), .i_line_ay(w_ay), .i_line_bx(w_bx), .i_line_by(w_by),
        .i_job_empty(w_jq_empty), .o_job_pop(w_job_pop), .i_job(w_jq_data),
        .o_lerp_start(w_lerp_start),
        .o_lerp_cx(w_lcx), .o_lerp_cy(w_lcy), .o_lerp_dx(w_ldx), .o_lerp_dy(w_ldy),
        .o_lerp_asc(w_asc), .o_lerp_aden(w_aden),
        .i_lerp_done(w_lerp_done), .i_lerp_x(w_lx), .i_lerp_y(w_ly),
        .i_out_full(w_oq_full), .o_out_push(w_out_push), .o_out_data(w_out_data)
    );

    phc_queue #(.WIDTH(OW), .DEPTH(OutDepth)) u_out_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_out_push), .o_full(w_oq_full), .i_data(w_out_data),
        .i_pop(pop), .o_empty(empty), .o_data(w_oq_data)
    );

    assign o_kind       = w_oq_data[OW-1];
    assign o_out_x      = w_oq_data[OW-2 -: CW];
    assign o_out_y      = w_oq_data[OW-2-CW -: CW];
    assign o_area       = w_oq_data[2*CW:1];
    assign o_end_of_run = w_oq_data[0];
endmodule
`default_nettype wire

[verif/polygon_halfplane_clip_area_tb.sv]
// Self-checking testbench for the half-plane polygon clipper with shoelace area.
`default_nettype none
module polygon_halfplane_clip_area_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import phc_pkg::*;

    localparam int W = CoordWidth;
    localparam int NumItems = 460;
    localparam int CycleLimit = 1500000;
    localparam int SettleCycles = 200;
    localparam logic signed [W-1:0] One = 32'sh0001_0000;
    localparam logic signed [W-1:0] CMax = 32'sh7fff_ffff;
    localparam logic signed [W-1:0] CMin = 32'sh8000_0000;

    typedef logic signed [127:0] t_wide;
    typedef struct packed {
        logic               kind;
        logic [W-1:0]       x;
        logic [W-1:0]       y;
        logic [2*W-1:0]     area;
        logic               eor;
    } t_clip_res;

    typedef enum logic {RowVert, RowLine} t_row_op;
    typedef struct {
        t_row_op            op;
        logic signed [W-1:0] a, b, c, d;
        logic               last;
        logic               lit;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic push, full, empty, pop;
    logic [W-1:0] i_vert_x, i_vert_y, i_cfg_data;
    logic i_last_vertex, i_cfg_wr_en;
    logic [CfgIdxWidth-1:0] i_cfg_index;
    logic o_kind, o_end_of_run;
    logic [W-1:0] o_out_x, o_out_y;
    logic [2*W-1:0] o_area;

    polygon_halfplane_clip_area i_dut (
        .i_clk, .i_rst_n, .push, .full, .i_vert_x, .i_vert_y, .i_last_vertex,
        .i_cfg_wr_en, .i_cfg_index, .i_cfg_data, .empty, .pop, .o_kind,
        .o_out_x, .o_out_y, .o_area, .o_end_of_run
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic signed [W-1:0] ln_ax, ln_ay, ln_bx, ln_by;
    logic have_first, have_out;
    logic signed [W-1:0] first_x, first_y, prev_x, prev_y;
    logic signed [W-1:0] ofirst_x, ofirst_y, oprev_x, oprev_y;
    logic signed [63:0] area2;

    t_clip_res clip_q[$];
    int  errors = 0;
    int  cycles = 0;
    bit  calm = 1'b0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic t_wide xprod(t_wide ax, t_wide ay, t_wide bx, t_wide by);
        return ax * by - ay * bx;
    endfunction

    function automatic logic signed [W-1:0] lerp_coord(t_wide c, t_wide d, t_wide asc,
                                                       t_wide aden);
        t_wide dv;
        logic [127:0] num, q;
        dv  = d - c;
        num = $unsigned(dv < 0 ? -dv : dv) * $unsigned(asc);
        q   = (2 * num + $unsigned(aden)) / (2 * $unsigned(aden));
        return (dv < 0) ? W'(c - $signed(q)) : W'(c + $signed(q));
    endfunction

    task automatic clear_run();
        have_first = 1'b0; have_out = 1'b0;
        first_x = '0; first_y = '0; prev_x = '0; prev_y = '0;
        ofirst_x = '0; ofirst_y = '0; oprev_x = '0; oprev_y = '0;
        area2 = '0;
    endtask

    task automatic emit_vertex(logic signed [W-1:0] x, logic signed [W-1:0] y,
                               ref t_clip_res res[$]);
        t_wide acc;
        res.insert(res.size(), '{kind: KindVertex, x: x, y: y, area: '0, eor: 1'b0});
        if (!have_out) begin
            have_out = 1'b1;
            ofirst_x = x; ofirst_y = y;
        end else begin
            acc = t_wide'(area2) + xprod(t_wide'(oprev_x) - ofirst_x,
                                         t_wide'(oprev_y) - ofirst_y,
                                         t_wide'(x) - ofirst_x, t_wide'(y) - ofirst_y);
            if (acc > t_wide'(64'sh7fff_ffff_ffff_ffff)) area2 = 64'sh7fff_ffff_ffff_ffff;
            else if (acc < t_wide'(-64'sh7fff_ffff_ffff_ffff - 1))
                area2 = 64'sh8000_0000_0000_0000;
            else area2 = acc[63:0];
        end
        oprev_x = x; oprev_y = y;
    endtask

    task automatic clip_edge(logic signed [W-1:0] cx, logic signed [W-1:0] cy,
                             logic signed [W-1:0] dx, logic signed [W-1:0] dy,
                             ref t_clip_res res[$]);
        t_wide vx, vy, sc, den, sd;
        vx  = t_wide'(ln_bx) - ln_ax;
        vy  = t_wide'(ln_by) - ln_ay;
        sc  = xprod(vx, vy, t_wide'(cx) - ln_ax, t_wide'(cy) - ln_ay);
        den = xprod(vx, vy, t_wide'(cx) - dx, t_wide'(cy) - dy);
        if (sc >= 0) emit_vertex(cx, cy, res);
        if (den != 0) begin
            sd = sc - den;
            // crossing when the side values straddle or touch zero
            if ((sc > 0 && sd <= 0) || (sc < 0 && sd >= 0) || sc == 0)
                emit_vertex(lerp_coord(cx, dx, sc < 0 ? -sc : sc, den < 0 ? -den : den),
                            lerp_coord(cy, dy, sc < 0 ? -sc : sc, den < 0 ? -den : den), res);
        end
    endtask

    task automatic predict_vertex(logic signed [W-1:0] x, logic signed [W-1:0] y, logic last,
                                  ref t_clip_res res[$]);
        if (!have_first) begin
            have_first = 1'b1;
            first_x = x; first_y = y;
        end else begin
            clip_edge(prev_x, prev_y, x, y, res);
        end
        prev_x = x; prev_y = y;
        if (last) begin
            clip_edge(x, y, first_x, first_y, res);
            res.insert(res.size(),
                       '{kind: KindArea, x: '0, y: '0, area: area2 >>> 1, eor: 1'b1});
            clear_run();
        end
    endtask

    // sender: push stays high across back-to-back items
    task automatic send_vertex(logic signed [W-1:0] x, logic signed [W-1:0] y, logic last,
                               logic lit);
        t_clip_res res[$];
        if (!calm && $urandom_range(99) < 28) begin
            push <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 40);
        end
        push <= 1'b1;
        i_vert_x <= x; i_vert_y <= y; i_last_vertex <= last;
        do @(posedge i_clk); while (full);
        predict_vertex(x, y, last, res);
        if (lit) begin
            // single vertex against a degenerate line: the vertex, then zero area
            res.delete();
            res.insert(res.size(), '{kind: KindVertex, x: x, y: y, area: '0, eor: 1'b0});
            res.insert(res.size(), '{kind: KindArea, x: '0, y: '0, area: '0, eor: 1'b1});
        end
        foreach (res[i]) clip_q.insert(clip_q.size(), res[i]);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (clip_q.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_line(logic signed [W-1:0] ax, logic signed [W-1:0] ay,
                              logic signed [W-1:0] bx, logic signed [W-1:0] by);
        logic [W-1:0] vals[5];
        logic [CfgIdxWidth-1:0] idx[5];
        vals = '{ax, ay, bx, by, $urandom};
        idx  = '{CfgLineStartX, CfgLineStartY, CfgLineEndX, CfgLineEndY,
                 CfgIdxWidth'($urandom_range(4, 7))};
        drain();
        for (int i = 0; i < 5; i++) begin
            i_cfg_wr_en <= 1'b1; i_cfg_index <= idx[i]; i_cfg_data <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
        ln_ax = ax; ln_ay = ay; ln_bx = bx; ln_by = by;
    endtask

    function automatic logic signed [W-1:0] rnd_coord(int mode);
        logic signed [W-1:0] picks[5];
        picks = '{CMin, CMax, '0, -1, 1};
        case (mode)
            0: return $signed(W'($urandom_range(0, 20 * One))) - 10 * One;
            1: return $urandom;
            default: return picks[$urandom_range(0, 4)];
        endcase
    endfunction

    // result side
    always @(posedge i_clk) begin
        t_clip_res e;
        if (i_rst_n && pop && !empty) begin
            if (clip_q.size() == 0) begin
                $error("result with nothing expected");
                errors++;
            end else begin
                e = clip_q.pop_front();
                if (o_kind !== e.kind) begin
                    $error("kind expected %0d got %0d", e.kind, o_kind); errors++;
                end
                if (o_out_x !== e.x) begin
                    $error("out_x expected %h got %h", e.x, o_out_x); errors++;
                end
                if (o_out_y !== e.y) begin
                    $error("out_y expected %h got %h", e.y, o_out_y); errors++;
                end
                if (o_area !== e.area) begin
                    $error("area expected %h got %h", e.area, o_area); errors++;
                end
                if (o_end_of_run !== e.eor) begin
                    $error("end_of_run expected %0d got %0d", e.eor, o_end_of_run); errors++;
                end
            end
        end
        pop <= calm || ($urandom_range(99) >= 28);
    end

    t_stim_row rows[$];

    initial begin
        int sent, nv, mode;
        i_rst_n <= 1'b0; push <= 1'b0; pop <= 1'b0;
        i_vert_x <= '0; i_vert_y <= '0; i_last_vertex <= 1'b0;
        i_cfg_wr_en <= 1'b0; i_cfg_index <= '0; i_cfg_data <= '0;
        ln_ax = '0; ln_ay = '0; ln_bx = '0; ln_by = '0;
        clear_run();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        rows = '{
            '{RowVert, CMax, CMin, 0, 0, 1, 1},
            '{RowVert, CMin, CMax, 0, 0, 1, 1},
            '{RowLine, 0, 0, 0, One, 0, 0},
            // square straddling the line
            '{RowVert, -2 * One, -One, 0, 0, 0, 0},
            '{RowVert, 2 * One, -One, 0, 0, 0, 0},
            '{RowVert, 2 * One, One, 0, 0, 0, 0},
            '{RowVert, -2 * One, One, 0, 0, 1, 0},
            // wholly on the right: empty clip
            '{RowVert, One, 0, 0, 0, 0, 0},
            '{RowVert, 3 * One, 0, 0, 0, 0, 0},
            '{RowVert, 2 * One, One, 0, 0, 1, 0},
            // vertex on the line, edge along the line
            '{RowVert, 0, -One, 0, 0, 0, 0},
            '{RowVert, 0, One, 0, 0, 0, 0},
            '{RowVert, -One, 0, 0, 0, 1, 0},
            '{RowVert, 5 * One, 7, 0, 0, 1, 0},
            '{RowLine, CMin, CMin, CMax, CMax, 0, 0},
            // extreme square: area saturates
            '{RowVert, CMax, CMin, 0, 0, 0, 0},
            '{RowVert, CMax, CMax, 0, 0, 0, 0},
            '{RowVert, CMin, CMax, 0, 0, 0, 0},
            '{RowVert, CMin, CMin, 0, 0, 1, 0},
            '{RowLine, CMax, CMax, CMin, CMin, 0, 0},
            '{RowVert, CMax, CMin, 0, 0, 0, 0},
            '{RowVert, CMin, CMax, 0, 0, 0, 0},
            '{RowVert, 0, CMin, 0, 0, 1, 0}
        };
        foreach (rows[i]) begin
            if (rows[i].op == RowLine) write_line(rows[i].a, rows[i].b, rows[i].c, rows[i].d);
            else send_vertex(rows[i].a, rows[i].b, rows[i].last, rows[i].lit);
        end

        sent = 0;
        for (int poly = 0; sent < NumItems; poly++) begin
            calm = (sent > 150 && sent < 250);
            if (poly % 8 == 0) begin
                mode = $urandom_range(0, 9);
                mode = (mode < 6) ? 0 : (mode < 8) ? 1 : 2;
                write_line(rnd_coord(mode), rnd_coord(mode), rnd_coord(mode), rnd_coord(mode));
            end
            nv = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 7);
            mode = $urandom_range(0, 9);
            mode = (mode < 7) ? 0 : (mode < 9) ? 1 : 2;
            for (int v = 0; v < nv; v++) begin
                send_vertex(rnd_coord(mode), rnd_coord(mode), v == nv - 1, 1'b0);
                sent++;
            end
        end
        calm = 1'b0;
        drain();
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
